// ===== src/stq_pkg.sv =====
`timescale 1ns / 1ps
package stq_pkg;

    localparam int SLOT_W    = 4;
    localparam int SLOTS     = 1 << SLOT_W;
    localparam int CNT_W     = SLOT_W + 1;
    localparam int TIME_BITS = 48;
    localparam int TMO_W     = 32;
    localparam int NT_W      = 32;
    localparam int ENTRY_W   = SLOT_W + TIME_BITS;

    localparam logic [NT_W-1:0] NT_EMPTY = '1;
    localparam logic [NT_W-1:0] NT_MAX   = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_EXPIRE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_NONE  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UNL,
        S_INS,
        S_INS_LAST,
        S_HEAD_RD,
        S_HEAD,
        S_EXP,
        S_EMIT
    } t_state;

    // ms from now to expiry: 0 when due, saturated to the positive range
    function automatic logic [NT_W-1:0] nt_of(input logic [TIME_BITS-1:0] exp_t,
                                              input logic [TIME_BITS-1:0] now_t);
        logic [TIME_BITS-1:0] diff;
        begin
            diff = exp_t - now_t;
            if (exp_t <= now_t) begin
                return '0;
            end else if (diff > TIME_BITS'(NT_MAX)) begin
                return NT_MAX;
            end else begin
                return diff[NT_W-1:0];
            end
        end
    endfunction

endpackage

// ===== src/stq_ram.sv =====
`timescale 1ns / 1ps
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== src/sorted_timer_queue.sv =====
`timescale 1ns / 1ps
// Channel   Handshake        Fields
// request   start / busy     i_operation, i_timer_id, i_timeout_ms, i_now_ms
// result    o_valid (1 cyc)  o_kind, o_fired_id, o_next_timeout, o_last
//
// Queue entries {id, expiry} sit in one RAM in expiry order, addressed as a
// ring from a head pointer. Arm/cancel walk the list through the RAM read
// port, one entry a cycle: an unlink walk, an insert walk, then the head
// lookup. Expire scans due entries and then sends one fired item per cycle
// after a RAM read. Reset is synchronous; busy stays high until the last
// result is out, and the receiver cannot stall results.
module sorted_timer_queue
    import stq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_operation,
    input  logic [SLOT_W-1:0]    i_timer_id,
    input  logic [TMO_W-1:0]     i_timeout_ms,
    input  logic [TIME_BITS-1:0] i_now_ms,
    output logic                 o_valid,
    output logic [1:0]           o_kind,
    output logic [SLOT_W-1:0]    o_fired_id,
    output logic signed [NT_W-1:0] o_next_timeout,
    output logic                 o_last
);

    t_state r_state, n_state;
    t_op    r_op;
    logic [SLOT_W-1:0]    r_id;
    logic [TIME_BITS-1:0] r_when, r_now;
    logic [SLOT_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [SLOTS-1:0]     r_armed, n_armed;
    logic [CNT_W-1:0]     r_pos, n_pos;
    logic                 r_rv, n_rv;
    logic [SLOT_W-1:0]    r_rpos, n_rpos;
    logic                 r_found, n_found;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [NT_W-1:0]      r_nt, n_nt;
    logic                 r_valid, n_valid;
    t_kind                r_kind, n_kind;
    logic [SLOT_W-1:0]    r_fid, n_fid;
    logic [NT_W-1:0]      r_onto, n_onto;
    logic                 r_last, n_last;

    logic                 rd_en, wr_en;
    logic [SLOT_W-1:0]    rd_pos, wr_pos;
    logic [ENTRY_W-1:0]   wr_data, rd_data;
    logic [SLOT_W-1:0]    rd_id;
    logic [TIME_BITS-1:0] rd_exp;
    logic [TIME_BITS:0]   sum;
    logic                 accept;

    assign rd_id  = rd_data[ENTRY_W-1 -: SLOT_W];
    assign rd_exp = rd_data[TIME_BITS-1:0];
    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign sum    = {1'b0, i_now_ms} + {{(TIME_BITS + 1 - TMO_W){1'b0}}, i_timeout_ms};

    stq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_head + wr_pos),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_head + rd_pos),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_operation);
            r_id   <= i_timer_id;
            r_now  <= i_now_ms;
            r_when <= sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        end
        r_pos  <= n_pos;
        r_rpos <= n_rpos;
        r_n    <= n_n;
        r_nt   <= n_nt;
        r_kind <= n_kind;
        r_fid  <= n_fid;
        r_onto <= n_onto;
        r_found <= n_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_armed <= '0;
            r_rv    <= 1'b0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_armed <= n_armed;
            r_rv    <= n_rv;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_rv    = 1'b0;
        n_rpos  = r_rpos;
        n_found = r_found;
        n_count = r_count;
        n_head  = r_head;
        n_armed = r_armed;
        n_n     = r_n;
        n_nt    = r_nt;
        n_valid = 1'b0;
        n_kind  = r_kind;
        n_fid   = r_fid;
        n_onto  = r_onto;
        n_last  = 1'b0;
        rd_en   = 1'b0;
        rd_pos  = '0;
        wr_en   = 1'b0;
        wr_pos  = '0;
        wr_data = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_op'(i_operation))
                        OP_ARM, OP_CANCEL: begin
                            if (r_armed[i_timer_id]) begin
                                n_state = S_UNL;
                                n_pos   = '0;
                                n_found = 1'b0;
                            end else if (t_op'(i_operation) == OP_ARM) begin
                                n_state = S_INS;
                                n_pos   = r_count;
                            end else begin
                                n_state = S_HEAD_RD;
                            end
                        end
                        OP_EXPIRE: begin
                            n_state = S_EXP;
                            n_pos   = '0;
                            n_n     = '0;
                        end
                        default: n_state = S_HEAD_RD;
                    endcase
                end
            end

            // forward walk: find the id, pull later entries down by one
            S_UNL: begin
                if (r_pos < r_count) begin
                    rd_en  = 1'b1;
                    rd_pos = r_pos[SLOT_W-1:0];
                    n_pos  = r_pos + CNT_W'(1);
                    n_rv   = 1'b1;
                    n_rpos = r_pos[SLOT_W-1:0];
                end
                if (r_rv) begin
                    if (r_found) begin
                        wr_en   = 1'b1;
                        wr_pos  = r_rpos - SLOT_W'(1);
                        wr_data = rd_data;
                    end else if (rd_id == r_id) begin
                        n_found = 1'b1;
                    end
                    if ({1'b0, r_rpos} == r_count - CNT_W'(1)) begin
                        n_count        = r_count - CNT_W'(1);
                        n_armed[r_id]  = 1'b0;
                        n_rv           = 1'b0;
                        n_pos          = r_count - CNT_W'(1);
                        n_state        = (r_op == OP_ARM) ? S_INS : S_HEAD_RD;
                    end
                end
            end

            // backward walk: push later-expiring entries up, drop new one in
            S_INS: begin
                if (r_pos != '0) begin
                    rd_en  = 1'b1;
                    rd_pos = SLOT_W'(r_pos - CNT_W'(1));
                    n_pos  = r_pos - CNT_W'(1);
                    n_rv   = 1'b1;
                    n_rpos = SLOT_W'(r_pos - CNT_W'(1));
                end
                if (r_rv) begin
                    wr_en  = 1'b1;
                    wr_pos = r_rpos + SLOT_W'(1);
                    if (rd_exp > r_when) begin
                        wr_data = rd_data;
                        if (r_rpos == '0) begin
                            n_state = S_INS_LAST;
                            n_rv    = 1'b0;
                        end
                    end else begin
                        wr_data       = {r_id, r_when};
                        n_count       = r_count + CNT_W'(1);
                        n_armed[r_id] = 1'b1;
                        n_state       = S_HEAD_RD;
                        n_rv          = 1'b0;
                    end
                end else if (r_pos == '0) begin
                    wr_en         = 1'b1;
                    wr_pos        = '0;
                    wr_data       = {r_id, r_when};
                    n_count       = r_count + CNT_W'(1);
                    n_armed[r_id] = 1'b1;
                    n_state       = S_HEAD_RD;
                end
            end

            S_INS_LAST: begin
                wr_en         = 1'b1;
                wr_pos        = '0;
                wr_data       = {r_id, r_when};
                n_count       = r_count + CNT_W'(1);
                n_armed[r_id] = 1'b1;
                n_state       = S_HEAD_RD;
            end

            S_HEAD_RD: begin
                rd_en   = 1'b1;
                rd_pos  = '0;
                n_state = S_HEAD;
            end

            S_HEAD: begin
                n_valid = 1'b1;
                n_kind  = KIND_ACK;
                n_fid   = '0;
                n_onto  = (r_count == '0) ? NT_EMPTY : nt_of(rd_exp, r_now);
                n_last  = 1'b1;
                n_state = S_IDLE;
            end

            // count due entries from the head; first not-due one sets the timeout
            S_EXP: begin
                if (r_pos < r_count) begin
                    rd_en  = 1'b1;
                    rd_pos = r_pos[SLOT_W-1:0];
                    n_pos  = r_pos + CNT_W'(1);
                    n_rv   = 1'b1;
                    n_rpos = r_pos[SLOT_W-1:0];
                end
                if (r_rv) begin
                    if (rd_exp <= r_now) begin
                        n_n = r_n + CNT_W'(1);
                        if ({1'b0, r_rpos} == r_count - CNT_W'(1)) begin
                            n_nt    = NT_EMPTY;
                            n_state = S_EMIT;
                            n_pos   = '0;
                            n_rv    = 1'b0;
                        end
                    end else begin
                        n_nt    = nt_of(rd_exp, r_now);
                        n_state = S_EMIT;
                        n_pos   = '0;
                        n_rv    = 1'b0;
                    end
                end else if (r_count == '0) begin
                    n_nt    = NT_EMPTY;
                    n_state = S_EMIT;
                    n_pos   = '0;
                end
            end

            S_EMIT: begin
                if (r_n == '0) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_NONE;
                    n_fid   = '0;
                    n_onto  = r_nt;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    if (r_pos < r_n) begin
                        rd_en  = 1'b1;
                        rd_pos = r_pos[SLOT_W-1:0];
                        n_pos  = r_pos + CNT_W'(1);
                        n_rv   = 1'b1;
                        n_rpos = r_pos[SLOT_W-1:0];
                    end
                    if (r_rv) begin
                        n_valid        = 1'b1;
                        n_kind         = KIND_FIRED;
                        n_fid          = rd_id;
                        n_onto         = r_nt;
                        n_armed[rd_id] = 1'b0;
                        if ({1'b0, r_rpos} == r_n - CNT_W'(1)) begin
                            n_last  = 1'b1;
                            n_head  = r_head + r_n[SLOT_W-1:0];
                            n_count = r_count - r_n;
                            n_rv    = 1'b0;
                            n_state = S_IDLE;
                        end
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_fired_id     = r_fid;
    assign o_next_timeout = r_onto;
    assign o_last         = r_last;

    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without an item in flight");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("still busy after last result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("queue count out of range");

    a_armed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(r_armed) == r_count))
        else $error("armed bits disagree with queue count");

endmodule
